[sv/tfc_pkg.sv]
// Shared types, constants and lookup tables of the task tier classifier.
package tfc_pkg;

  typedef logic [2:0] op_t;

  localparam op_t OP_WAKE   = 3'd0;
  localparam op_t OP_RUN    = 3'd1;
  localparam op_t OP_STOP   = 3'd2;
  localparam op_t OP_TICK   = 3'd3;
  localparam op_t OP_ENQ    = 3'd4;
  localparam op_t OP_REMOVE = 3'd5;

  localparam logic [1:0] CFG_QUANTUM = 2'd0;
  localparam logic [1:0] CFG_BONUS   = 2'd1;
  localparam logic [1:0] CFG_PERMIL  = 2'd2;

  localparam logic [24:0] QUANTUM_RST = 25'd2000000;
  localparam logic [24:0] BONUS_RST   = 25'd8000000;
  localparam logic [10:0] PERMIL_RST  = 11'd50;

  localparam logic [6:0]  START_SCORE  = 7'd50;
  localparam logic [2:0]  START_TIER   = 3'd4;
  localparam logic [2:0]  VICTIM_TIER  = 3'd4;
  localparam logic [2:0]  TIER_BG      = 3'd6;
  localparam logic [6:0]  MAX_SCORE    = 7'd100;
  localparam logic [6:0]  SCORE_PENALTY = 7'd10;
  localparam logic [31:0] LONG_SLEEP_NS = 32'd33000000;
  localparam logic [15:0] AVG_SAT      = 16'd65535;
  localparam logic [4:0]  CHECK_WINDOW = 5'd10;
  localparam logic [4:0]  VIOL_LIMIT   = 5'd3;
  localparam logic [4:0]  CNT_SAT      = 5'd15;

  // Item handed from the front to the back.
  typedef struct packed {
    op_t         op;
    logic [5:0]  idx;
    logic [31:0] now;
    logic        in_range;
  } cmd_t;

  // One task record as held in the table.
  typedef struct packed {
    logic        valid;
    logic        wake_pending;
    logic        run_seen;
    logic [15:0] avg;
    logic [15:0] deficit;
    logic [6:0]  score;
    logic [2:0]  tier;
    logic [3:0]  checks;
    logic [3:0]  viol;
    logic [31:0] last_wake;
    logic [31:0] run_start;
    logic [26:0] slice;
  } rec_t;

  function automatic logic [31:0] starve_limit(input logic [2:0] t);
    logic [31:0] v;
    unique case (t)
      3'd0:    v = 32'd5000000;
      3'd1:    v = 32'd3000000;
      3'd2:    v = 32'd4000000;
      3'd3:    v = 32'd8000000;
      3'd4:    v = 32'd16000000;
      3'd5:    v = 32'd40000000;
      default: v = 32'd100000000;
    endcase
    return v;
  endfunction

  function automatic logic [10:0] slice_mult(input logic [2:0] t);
    logic [10:0] v;
    unique case (t)
      3'd0:    v = 11'd717;
      3'd1:    v = 11'd819;
      3'd2:    v = 11'd922;
      3'd3:    v = 11'd1024;
      3'd4:    v = 11'd1126;
      3'd5:    v = 11'd1229;
      3'd6:    v = 11'd1331;
      default: v = 11'd1024;
    endcase
    return v;
  endfunction

  // Zero means no budget.
  function automatic logic [31:0] wait_limit(input logic [2:0] t);
    logic [31:0] v;
    unique case (t)
      3'd0:    v = 32'd100000;
      3'd1:    v = 32'd750000;
      3'd2:    v = 32'd2000000;
      3'd3:    v = 32'd4000000;
      3'd4:    v = 32'd8000000;
      3'd5:    v = 32'd20000000;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] tier_of(input logic [6:0] score, input logic [15:0] avg);
    logic [2:0] t;
    priority if (score < 7'd30)                 t = 3'd6;
    else if (score < 7'd50)                     t = 3'd5;
    else if (score < 7'd70)                     t = 3'd4;
    else if (score < 7'd90)                     t = 3'd3;
    else if (score < MAX_SCORE)                 t = 3'd2;
    else if (avg != 16'd0 && avg < 16'd50)      t = 3'd0;
    else if (avg != 16'd0 && avg < 16'd500)     t = 3'd1;
    else                                        t = 3'd2;
    return t;
  endfunction

endpackage

[sv/tfc_ifs.sv]
// Handshake interfaces of the event, result and configuration channels.
interface tfc_evt_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [5:0]  task_index;
  logic [31:0] now_ts;
  modport source (output valid, op, task_index, now_ts, input ready);
  modport sink   (input valid, op, task_index, now_ts, output ready);
endinterface

interface tfc_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  tier;
  logic [26:0] slice_ns;
  logic        preempt;
  logic        victim;
  logic        known;
  modport source (output valid, tier, slice_ns, preempt, victim, known, input ready);
  modport sink   (input valid, tier, slice_ns, preempt, victim, known, output ready);
endinterface

interface tfc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [24:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/task_tier_classifier.sv]
// Top level of the task tier classifier: configuration registers, front end and back end.
//
//  channel | direction | handshake    | payload
//  evt     | in        | valid/ready  | op, task_index, now_ts
//  res     | out       | valid/ready  | tier, slice_ns, preempt, victim, known
//  cfg     | in        | valid/ready  | index, data
//
// Each item passes through the back end in order: table read, record update,
// slice multiply, write-back into the result register.
// After reset a clearing pass empties the table slot by slot; no item
// is accepted meanwhile, configuration writes are taken at any time.
// A two-item queue lets the front accept while the back works or the result
// register waits to be taken.
module task_tier_classifier #(
  parameter int TASK_SLOTS = 64
) (
  input logic       clk,
  input logic       rst,
  tfc_evt_if.sink   evt,
  tfc_res_if.source res,
  tfc_cfg_if.sink   cfg
);
  import tfc_pkg::*;

  logic [24:0] quantum;
  logic [24:0] bonus;
  logic [10:0] permil;
  cmd_t        q_cmd;
  logic        q_valid;
  logic        q_pop;
  logic        clearing;

  // Hold configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= QUANTUM_RST;
      bonus   <= BONUS_RST;
      permil  <= PERMIL_RST;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_QUANTUM) quantum <= cfg.data;
      if (cfg.index == CFG_BONUS)   bonus   <= cfg.data;
      if (cfg.index == CFG_PERMIL)  permil  <= cfg.data[10:0];
    end
  end

  tfc_front #(.TASK_SLOTS(TASK_SLOTS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .evt     (evt),
    .hold    (clearing),
    .q_cmd   (q_cmd),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  tfc_back #(.TASK_SLOTS(TASK_SLOTS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_cmd    (q_cmd),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .clearing (clearing),
    .quantum  (quantum),
    .bonus    (bonus),
    .permil   (permil),
    .res      (res)
  );

  // No item enters during the clearing pass
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    evt.valid && evt.ready |-> !clearing)
    else $error("item accepted during clearing pass");

  // An unknown record reports the start tier
  a_unknown_tier: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.known |-> res.tier == START_TIER)
    else $error("unknown record with non-default tier");

  // Preempt and victim come from different events
  a_flags_apart: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !(res.preempt && res.victim))
    else $error("preempt and victim both set");

  // Queue never pops while empty
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule

[sv/tfc_front.sv]
// Front end: accepts events, classifies them and queues them for the back end.
module tfc_front #(
  parameter int TASK_SLOTS = 64
) (
  input  logic          clk,
  input  logic          rst,
  tfc_evt_if.sink       evt,
  input  logic          hold,
  output tfc_pkg::cmd_t q_cmd,
  output logic          q_valid,
  input  logic          q_pop
);
  import tfc_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       cls;
  logic       push;

  // Classify: unused op codes act as a query, out-of-range indexes are unknown
  always_comb begin
    cls.op       = (evt.op > OP_REMOVE) ? OP_ENQ : evt.op;
    cls.idx      = evt.task_index;
    cls.now      = evt.now_ts;
    cls.in_range = 32'(evt.task_index) < 32'(TASK_SLOTS);
  end

  assign evt.ready = !hold && (count != 2'd2);
  assign push      = evt.valid && evt.ready;
  assign q_valid   = count != 2'd0;
  assign q_cmd     = slots[rd_ptr];

  // Store item
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cls;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

[sv/tfc_back.sv]
// Back end: record table, read-modify-write of one record per item, result register.
module tfc_back #(
  parameter int TASK_SLOTS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  tfc_pkg::cmd_t q_cmd,
  input  logic          q_valid,
  output logic          q_pop,
  output logic          clearing,
  input  logic [24:0]   quantum,
  input  logic [24:0]   bonus,
  input  logic [10:0]   permil,
  tfc_res_if.source     res
);
  import tfc_pkg::*;

  localparam int AW = $clog2(TASK_SLOTS);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CALC  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_WB    = 3'd4;

  rec_t        mem [TASK_SLOTS];
  logic [2:0]  state;
  logic [AW-1:0] clr_idx;
  cmd_t        cmd_r;
  rec_t        rec_q;
  rec_t        rec_n;
  logic        known_n;
  logic        preempt_n;
  logic        victim_n;
  logic        stop_n;
  logic [25:0] thresh;

  rec_t        c;
  logic        known_c;
  logic        preempt_c;
  logic        victim_c;
  logic        stop_c;
  logic        out_free;
  logic        mem_we;
  logic [AW-1:0] wr_addr;
  rec_t        wr_data;
  logic [25:0] base;
  logic [36:0] prod;

  assign clearing = state == S_CLEAR;
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign out_free = !res.valid || res.ready;

  // Table write and registered read
  assign mem_we  = clearing || ((state == S_WB) && out_free && known_n);
  assign wr_addr = clearing ? clr_idx : AW'(cmd_r.idx);
  assign wr_data = clearing ? '0 : rec_n;

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    if (q_pop) rec_q <= mem[AW'(q_cmd.idx)];
  end

  // Sparse threshold follows the configuration
  always_ff @(posedge clk) begin
    thresh <= 26'((36'(quantum) * 36'(permil)) >> 10);
  end

  // Record update for the item in hand
  always_comb begin
    rec_t              r;
    logic              have;
    logic [31:0]       wait_ns;
    logic [31:0]       runtime;
    logic [31:0]       lim;
    logic [4:0]        chk;
    logic [4:0]        vl;
    logic signed [8:0] sc;
    logic [15:0]       meas;
    logic signed [16:0] diff;
    logic signed [16:0] avg_sum;
    logic [21:0]       run_us;
    r         = rec_q;
    have      = cmd_r.in_range && rec_q.valid;
    wait_ns   = cmd_r.now - rec_q.last_wake;
    runtime   = cmd_r.now - rec_q.run_start;
    lim       = 32'd0;
    chk       = 5'd0;
    vl        = 5'd0;
    sc        = 9'sd0;
    meas      = 16'd0;
    diff      = 17'sd0;
    avg_sum   = 17'sd0;
    run_us    = runtime[31:10];
    known_c   = have;
    preempt_c = 1'b0;
    victim_c  = 1'b0;
    stop_c    = 1'b0;
    if (cmd_r.op == OP_RUN && cmd_r.in_range && !have) begin
      r              = '0;
      r.valid        = 1'b1;
      r.slice        = 27'(quantum);
      r.deficit      = 16'((26'(quantum) + 26'(bonus)) >> 10);
      r.score        = START_SCORE;
      r.tier         = START_TIER;
    end
    c = r;
    if (cmd_r.op == OP_RUN && cmd_r.in_range) begin
      known_c  = 1'b1;
      victim_c = r.tier >= VICTIM_TIER;
      wait_ns  = cmd_r.now - r.last_wake;
      if (r.wake_pending) begin
        chk = 5'(r.checks) + 5'd1;
        vl  = 5'(r.viol);
        lim = wait_limit(r.tier);
        if (wait_ns > LONG_SLEEP_NS) c.avg = r.avg >> 1;
        if (lim != 32'd0 && wait_ns > lim) vl = vl + 5'd1;
        if (chk >= CHECK_WINDOW && r.tier < TIER_BG) begin
          if (vl >= VIOL_LIMIT) begin
            c.score = (r.score > SCORE_PENALTY) ? r.score - SCORE_PENALTY : 7'd0;
          end
          chk = 5'd0;
          vl  = 5'd0;
        end else begin
          if (chk > CNT_SAT) chk = CNT_SAT;
          if (vl > CNT_SAT) vl = CNT_SAT;
        end
        c.checks       = chk[3:0];
        c.viol         = vl[3:0];
        c.wake_pending = 1'b0;
      end
      c.run_start = cmd_r.now;
      c.run_seen  = 1'b1;
    end else if (have) begin
      unique case (cmd_r.op)
        OP_WAKE: begin
          c.last_wake    = cmd_r.now;
          c.wake_pending = 1'b1;
        end
        OP_STOP: begin
          if (r.run_seen) begin
            stop_c = 1'b1;
            sc = $signed({2'b00, r.score}) + ((runtime < 32'(thresh)) ? 9'sd4 : -9'sd6);
            if (sc < 9'sd0) sc = 9'sd0;
            if (sc > $signed({2'b00, MAX_SCORE})) sc = $signed({2'b00, MAX_SCORE});
            meas = (run_us > 22'(AVG_SAT)) ? AVG_SAT : run_us[15:0];
            diff = $signed({1'b0, meas}) - $signed({1'b0, r.avg});
            avg_sum = $signed({1'b0, r.avg}) + (diff >>> 3);
            c.avg = (r.avg == 16'd0) ? meas : avg_sum[15:0];
            c.deficit = (22'(r.deficit) > run_us) ? r.deficit - run_us[15:0] : 16'd0;
            c.score = sc[6:0];
            c.tier  = tier_of(sc[6:0], c.avg);
          end
        end
        OP_TICK: begin
          preempt_c = r.run_seen && (runtime > starve_limit(r.tier));
        end
        OP_REMOVE: begin
          c.valid = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Slice from the new deficit and tier
  always_comb begin
    base = ({rec_n.deficit, 10'd0} < 26'(quantum)) ? 26'(quantum) : {rec_n.deficit, 10'd0};
    prod = 37'(base) * 37'(slice_mult(rec_n.tier));
  end

  // Sequence one item through read, update, slice and write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      res.valid <= 1'b0;
    end else begin
      // Hold the result until taken, load a new one when write-back completes
      res.valid <= ((state == S_WB) && out_free) || (res.valid && !res.ready);
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == AW'(TASK_SLOTS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            cmd_r <= q_cmd;
            state <= S_CALC;
          end
        end
        S_CALC: begin
          rec_n     <= c;
          known_n   <= known_c;
          preempt_n <= preempt_c;
          victim_n  <= victim_c;
          stop_n    <= stop_c;
          state     <= S_MUL;
        end
        S_MUL: begin
          if (stop_n) rec_n.slice <= prod[36:10];
          state <= S_WB;
        end
        S_WB: begin
          if (out_free) begin
            res.tier     <= known_n ? rec_n.tier : START_TIER;
            res.slice_ns <= known_n ? rec_n.slice : 27'(quantum);
            res.preempt  <= preempt_n;
            res.victim   <= victim_n;
            res.known    <= known_n;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
